@@ hw/rtl/sha224_pkg.sv @@
// Package for the SHA-224 hash engine: state enum, command and status structs,
// round constants, initial values and the SHA-256 round functions. No dependencies.
package sha224_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_UPDATE,
		ST_PAD,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic       take_byte;
		logic       start_block;
		logic       round;
		logic       update_cv;
		logic       pad_write;
		logic       pad_mark;
		logic       pad_last;
		logic       out_load;
		logic       restart;
	} dp_cmd_t;

	typedef struct packed {
		logic       block_full;
		logic [5:0] fill;
		logic       round_last;
	} dp_stat_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic [31:0] IV [8] = '{
		32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
		32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
	};

	localparam logic [31:0] K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

@@ hw/rtl/sha224_datapath.sv @@
// SHA-224 datapath: block buffer as a 16-word schedule window, chaining value,
// working variables, bit count and digest output register. Uses sha224_pkg.
module sha224_datapath import sha224_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [7:0]  data_byte,
	input  logic        out_take,
	output dp_stat_t    stat,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	output logic        out_busy
);

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] cv_q [8];
	logic [63:0] bits_q;
	logic [6:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [31:0] ob_q [7];
	logic [2:0]  oidx_q;
	logic        obusy_q;

	logic [7:0]  wr_byte;
	logic [31:0] t1, t2, w_new;
	logic [3:0]  wi;
	logic [1:0]  bi;

	always_comb begin
		t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ K[rnd_q] + w_q[0];
		t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
		wi = fill_q[5:2];
		bi = fill_q[1:0];
		if (cmd.take_byte)
			wr_byte = data_byte;
		else if (cmd.pad_mark)
			wr_byte = PAD_BYTE;
		else if (cmd.pad_last)
			wr_byte = bits_q[63 - 8 * (fill_q[2:0]) -: 8];
		else
			wr_byte = 8'h00;
	end

	assign stat.fill       = fill_q[5:0];
	assign stat.block_full = fill_q[6];
	assign stat.round_last = (rnd_q == 6'd63);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			bits_q  <= '0;
			rnd_q   <= '0;
			oidx_q  <= '0;
			obusy_q <= 1'b0;
			for (int i = 0; i < 16; i++)
				w_q[i] <= '0;
			for (int i = 0; i < 8; i++) begin
				cv_q[i] <= IV[i];
				v_q[i]  <= '0;
			end
			for (int i = 0; i < 7; i++)
				ob_q[i] <= '0;
		end else begin
			if (cmd.start_block || cmd.restart)
				fill_q <= '0;
			else if (cmd.take_byte || cmd.pad_write)
				fill_q <= fill_q + 7'd1;
			if (cmd.restart)
				bits_q <= '0;
			else if (cmd.take_byte)
				bits_q <= bits_q + 64'd8;
			if (cmd.round) begin
				for (int i = 0; i < 15; i++)
					w_q[i] <= w_q[i + 1];
				w_q[15] <= w_new;
			end else if (cmd.take_byte || cmd.pad_write)
				w_q[wi][31 - 8 * bi -: 8] <= wr_byte;
			if (cmd.start_block) begin
				rnd_q <= '0;
				for (int i = 0; i < 8; i++)
					v_q[i] <= cv_q[i];
			end else if (cmd.round) begin
				rnd_q <= rnd_q + 6'd1;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			if (cmd.restart)
				for (int i = 0; i < 8; i++)
					cv_q[i] <= IV[i];
			else if (cmd.update_cv)
				for (int i = 0; i < 8; i++)
					cv_q[i] <= cv_q[i] + v_q[i];
			if (cmd.out_load) begin
				for (int i = 0; i < 7; i++)
					ob_q[i] <= cv_q[i];
				oidx_q  <= '0;
				obusy_q <= 1'b1;
			end else if (out_take) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd6)
					obusy_q <= 1'b0;
			end
		end
	end

	assign digest_word = ob_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd6);
	assign out_busy    = obusy_q;

endmodule

@@ hw/rtl/sha224_ctrl.sv @@
// SHA-224 controller: sequences byte intake, 64 compression rounds, padding
// and digest hand-off. Uses sha224_pkg.
module sha224_ctrl import sha224_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        byte_valid,
	input  logic        message_end,
	input  dp_stat_t    stat,
	input  logic        out_busy,
	output logic        in_ready,
	output dp_cmd_t     cmd
);

	ctrl_state_t state_q, state_d;
	logic        fin_q, fin_d;
	logic        pad80_q, pad80_d;
	// current padding block carries the length field
	logic        lenblk_q, lenblk_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fin_q    <= 1'b0;
			pad80_q  <= 1'b0;
			lenblk_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fin_q    <= fin_d;
			pad80_q  <= pad80_d;
			lenblk_q <= lenblk_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		fin_d    = fin_q;
		pad80_d  = pad80_q;
		lenblk_d = lenblk_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_byte = byte_valid;
					fin_d    = message_end;
					pad80_d  = 1'b1;
					lenblk_d = 1'b0;
					if (byte_valid && stat.fill == 6'd63)
						state_d = ST_ROUND;
					else if (message_end)
						state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				// 0x80, zeros up to the length field, then 8 length bytes
				if (stat.block_full)
					state_d = ST_ROUND;
				else begin
					cmd.pad_write = 1'b1;
					if (pad80_q) begin
						cmd.pad_mark = 1'b1;
						pad80_d  = 1'b0;
						lenblk_d = (stat.fill < LEN_POS);
					end else if (lenblk_q && stat.fill >= LEN_POS)
						cmd.pad_last = 1'b1;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (stat.round_last)
					state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update_cv = 1'b1;
				if (!fin_q)
					state_d = ST_IDLE;
				else if (lenblk_q)
					state_d = ST_EMIT;
				else begin
					lenblk_d = 1'b1;
					state_d  = ST_PAD;
				end
			end
			ST_EMIT: begin
				if (!out_busy) begin
					cmd.out_load = 1'b1;
					cmd.restart  = 1'b1;
					fin_d   = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (state_d == ST_ROUND && state_q != ST_ROUND)
			cmd.start_block = 1'b1;
	end

endmodule

@@ hw/rtl/sha224_hash_engine.sv @@
// SHA-224 hash engine, one message byte per transfer, seven digest words out.
// A byte that completes a block holds the input through intake, the 64 rounds and the
// chaining update; other bytes are taken without a stall. A final transfer adds padding
// and one or two compressions; bytes are taken while a digest drains, the next digest
// waits for the previous one.
// Reset (arst_n, asynchronous) loads the SHA-224 initial values and clears counts.
module sha224_hash_engine import sha224_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        message_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     busy;

	sha224_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .byte_valid, .message_end,
		.stat, .out_busy(busy), .in_ready, .cmd
	);

	sha224_datapath u_dp (
		.clk, .arst_n, .cmd, .data_byte, .out_take(out_valid && out_ready),
		.stat, .digest_word, .word_index, .last_word, .out_busy(busy)
	);

	assign out_valid = busy;

`ifndef SYNTH
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_word |-> word_index == 3'd6)
		else $error("last word index");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word)
			&& $stable(word_index))
		else $error("digest word changed while waiting");
	a_round_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round |-> !cmd.take_byte && !cmd.pad_write)
		else $error("buffer write during rounds");
`endif

endmodule
